// ===== rtl/core/bfn_pkg.sv =====
// ----------------------------------------------------------------------------
// bfn_pkg
// shared constants, operation codes and controller/datapath types for the
// bitmap find-next engine
// ----------------------------------------------------------------------------
package bfn_pkg;

  localparam int BITMAP_BITS = 256;
  localparam int WORD_BITS   = 32;
  localparam int NUM_WORDS   = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int FUNC_W      = 3;
  localparam int POS_W       = 8;
  localparam int LIMIT_W     = 9;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WORD_IDX_W-1:0] word_idx_t;
  typedef logic [BIT_IDX_W-1:0]  bit_idx_t;
  typedef logic [FUNC_W-1:0]     func_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [LIMIT_W-1:0]    limit_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET        = 3'd0,
    FN_CLEAR      = 3'd1,
    FN_TEST       = 3'd2,
    FN_FIND_SET   = 3'd3,
    FN_FIND_CLEAR = 3'd4
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } bfn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic out_free;
  } bfn_sts_t;

  // index of the lowest set bit, zero when none
  function automatic bit_idx_t lowest_set(input word_t x);
    word_t    iso;
    bit_idx_t idx;
    iso = x & (~x + word_t'(1));
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        idx = idx | bit_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/bfn_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfn_ctrl
// sequencer: takes an item, steps the word scan, commits the result
// ----------------------------------------------------------------------------
module bfn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bfn_pkg::bfn_sts_t sts,
  output bfn_pkg::bfn_cmd_t cmd
);
  import bfn_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.done) begin
          // hold until the output register can take the result
          if (sts.out_free) begin
            cmd.commit = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bfn_dp.sv =====
// ----------------------------------------------------------------------------
// bfn_dp
// bitmap storage, item registers, one-word-per-cycle match logic and the
// output register
// ----------------------------------------------------------------------------
module bfn_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  bfn_pkg::func_t       func,
  input  bfn_pkg::pos_t        bit_position,
  input  bfn_pkg::limit_t      search_limit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 bit_value,
  output bfn_pkg::limit_t      found_position,
  input  bfn_pkg::bfn_cmd_t    cmd,
  output bfn_pkg::bfn_sts_t    sts
);
  import bfn_pkg::*;

  word_t     bitmap [NUM_WORDS];
  func_t     func_q;
  pos_t      pos_q;
  limit_t    lim_q;
  word_idx_t w_q;

  word_t     word_rd;
  word_t     cand;
  logic      want;
  logic      hit;
  bit_idx_t  hit_bit;
  logic      is_find;
  logic      start_past;
  logic      last_word;
  logic      in_range;
  word_idx_t pos_word;
  bit_idx_t  pos_bit;
  limit_t    next_base;
  logic      res_bit;
  limit_t    res_pos;

  assign pos_word = word_idx_t'(pos_q >> BIT_IDX_W);
  assign pos_bit  = pos_q[BIT_IDX_W-1:0];
  assign in_range = ({1'b0, pos_q} < limit_t'(BITMAP_BITS));
  assign word_rd  = bitmap[w_q];
  assign is_find  = (func_q == FN_FIND_SET) || (func_q == FN_FIND_CLEAR);
  assign want     = (func_q == FN_FIND_SET);

  // candidate bits of the current word: matching value, at or past start,
  // below the limit
  always_comb begin
    limit_t idx;
    for (int b = 0; b < WORD_BITS; b++) begin
      idx     = limit_t'({w_q, bit_idx_t'(b)});
      cand[b] = (word_rd[b] == want) && (idx >= limit_t'(pos_q)) && (idx < lim_q);
    end
  end

  assign hit        = |cand;
  assign hit_bit    = lowest_set(cand);
  assign start_past = (limit_t'(pos_q) >= lim_q);
  assign next_base  = limit_t'({({1'b0, w_q} + (WORD_IDX_W+1)'(1)), {BIT_IDX_W{1'b0}}});
  assign last_word  = (w_q == word_idx_t'(NUM_WORDS - 1)) || (next_base >= lim_q);

  assign sts.done     = !is_find || start_past || hit || last_word;
  assign sts.out_free = !out_valid || !out_stall;

  always_comb begin
    res_bit = 1'b0;
    res_pos = '0;
    case (func_q)
      FN_TEST: begin
        res_bit = in_range && word_rd[pos_bit];
      end
      FN_FIND_SET, FN_FIND_CLEAR: begin
        if (!start_past && hit) begin
          res_pos = limit_t'({w_q, hit_bit});
        end else begin
          res_pos = lim_q;
        end
      end
      default: begin
        res_bit = 1'b0;
      end
    endcase
  end

  // item registers and word pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      pos_q  <= bit_position;
      lim_q  <= (search_limit > limit_t'(BITMAP_BITS)) ? limit_t'(BITMAP_BITS)
                                                       : search_limit;
      w_q    <= word_idx_t'(bit_position >> BIT_IDX_W);
    end else if (cmd.step) begin
      w_q <= w_q + word_idx_t'(1);
    end
  end

  // bitmap words, set and clear land at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        bitmap[i] <= '0;
      end
    end else if (cmd.commit && in_range &&
                 ((func_q == FN_SET) || (func_q == FN_CLEAR))) begin
      bitmap[pos_word][pos_bit] <= (func_q == FN_SET);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      bit_value      <= res_bit;
      found_position <= res_pos;
    end
  end

endmodule

// ===== rtl/core/bitmap_find_next_engine.sv =====
// ----------------------------------------------------------------------------
// bitmap_find_next_engine
// 256-bit bitmap with set, clear, test and find-next-set/clear operations
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries func, bit_position and
//   search_limit; a transfer happens on a clock edge with in_valid high and
//   in_stall low. every input transfer yields exactly one output transfer on
//   the output channel (out_valid / out_stall) with bit_value and
//   found_position.
//   the engine works on one item at a time. after a transfer the word scan
//   visits one bitmap word per cycle (one word for set, clear, test and
//   unused codes, up to eight words for a find), then the result moves into
//   the output register. a new item is taken only after the result is
//   committed; the scan reads the bitmap one word at a time through its
//   single word read port.
//   a finished result may wait in the output register while the next item
//   is taken and scanned. if out_stall keeps the register full, the scan
//   holds its result and in_stall stays high until the register frees.
//   set and clear update the bitmap when their result is committed.
//   reset (rst, synchronous) clears every bitmap bit, empties the output
//   register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module bitmap_find_next_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  bfn_pkg::func_t  func,
  input  bfn_pkg::pos_t   bit_position,
  input  bfn_pkg::limit_t search_limit,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            bit_value,
  output bfn_pkg::limit_t found_position
);
  import bfn_pkg::*;

  // command and status between sequencer and datapath
  bfn_cmd_t cmd;
  bfn_sts_t sts;

  // sequencer: idle / run
  bfn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bitmap, word scan and output register
  bfn_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .func           (func),
    .bit_position   (bit_position),
    .search_limit   (search_limit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bit_value      (bit_value),
    .found_position (found_position),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== rtl/core/bfn_checker.sv =====
// ----------------------------------------------------------------------------
// bfn_checker
// port-level checks for the bitmap find-next engine, bound to the top level
// ----------------------------------------------------------------------------
module bfn_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input bfn_pkg::limit_t found_position
);
  import bfn_pkg::*;

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // one item at a time: busy right after an input transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

  // stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(found_position))
    else $error("result changed under stall");

endmodule

bind bitmap_find_next_engine bfn_checker u_bfn_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .found_position (found_position)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bitmap find-next engine: a directed pass over
// boundary positions, limits and operation codes, then random phases that
// fill, drain and mix the bitmap, with random idling on both channels and a
// local bitmap image that predicts every result in order
// ----------------------------------------------------------------------------
module tb_top;
  import bfn_pkg::*;

  // cycles with no transfer on either channel before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // settle time after the last result, covers the longest scan
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_IDLE     = 6;
  localparam int FUNC_CODES   = 2 ** FUNC_W;

  typedef struct {
    logic   bit_value;
    limit_t found_position;
  } bitmap_result_t;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  func_t   func;
  pos_t    bit_position;
  limit_t  search_limit;
  logic    out_valid;
  logic    out_stall;
  logic    bit_value;
  limit_t  found_position;

  // local image of the bitmap, updated as each transfer is accepted
  word_t          bitmap_image [NUM_WORDS];
  bitmap_result_t expected_results [$];

  int  mismatch_count;
  int  results_checked;
  int  op_count [FUNC_CODES];
  int  find_hits;
  int  find_misses;
  int  idle_cycles;
  int  stall_left;
  bit  in_idle_on;
  bit  out_idle_on;

  bitmap_find_next_engine DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .bit_position   (bit_position),
    .search_limit   (search_limit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bit_value      (bit_value),
    .found_position (found_position)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // bitmap image and result prediction
  // --------------------------------------------------------------------------

  function automatic logic image_bit(input int p);
    if (p >= BITMAP_BITS) begin
      return 1'b0;
    end
    return bitmap_image[p / WORD_BITS][p % WORD_BITS];
  endfunction

  // applies one operation to the image and works out the result it yields
  function automatic void predict_bitmap_op(input func_t f, input pos_t p,
                                            input limit_t l,
                                            output bitmap_result_t res);
    int   lim_sat;
    int   idx;
    logic want;
    res.bit_value      = 1'b0;
    res.found_position = '0;
    // a limit past the end of the bitmap stops at the end
    lim_sat = (int'(l) > BITMAP_BITS) ? BITMAP_BITS : int'(l);
    case (f)
      FN_SET: begin
        if (int'(p) < BITMAP_BITS) begin
          bitmap_image[int'(p) / WORD_BITS][int'(p) % WORD_BITS] = 1'b1;
        end
      end
      FN_CLEAR: begin
        if (int'(p) < BITMAP_BITS) begin
          bitmap_image[int'(p) / WORD_BITS][int'(p) % WORD_BITS] = 1'b0;
        end
      end
      FN_TEST: begin
        res.bit_value = image_bit(int'(p));
      end
      FN_FIND_SET, FN_FIND_CLEAR: begin
        want = (f == FN_FIND_SET);
        // no match, or a start at or past the limit, returns the limit
        res.found_position = limit_t'(lim_sat);
        for (idx = int'(p); idx < lim_sat; idx++) begin
          if (image_bit(idx) == want) begin
            res.found_position = limit_t'(idx);
            break;
          end
        end
        if (int'(res.found_position) == lim_sat) begin
          find_misses++;
        end else begin
          find_hits++;
        end
      end
      default: begin
        // unused codes leave the bitmap alone and return zeros
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // input side: one transfer, with a random gap ahead of it
  // --------------------------------------------------------------------------

  task automatic send_item(input func_t f, input pos_t p, input limit_t l);
    int             gap;
    bitmap_result_t res;
    gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    bit_position <= p;
    search_limit <= l;
    // hold the payload until the engine takes it
    do @(posedge clk); while (in_stall);
    predict_bitmap_op(f, p, l, res);
    expected_results.push_back(res);
    op_count[int'(f)]++;
  endtask

  // --------------------------------------------------------------------------
  // output side: random stall per result, in-order compare
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    bitmap_result_t exp_res;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result bit_value=%0b found=%0d",
                                    bit_value, found_position));
        end else begin
          exp_res = expected_results.pop_front();
          if (bit_value !== exp_res.bit_value) begin
            report_mismatch($sformatf("result %0d bit_value got %0b want %0b",
                                      results_checked, bit_value,
                                      exp_res.bit_value));
          end
          if (found_position !== exp_res.found_position) begin
            report_mismatch($sformatf("result %0d found_position got %0d want %0d",
                                      results_checked, found_position,
                                      exp_res.found_position));
          end
        end
        // draw the stall ahead of the next result
        stall_left = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // hang detector: any transfer on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // random field helpers
  // --------------------------------------------------------------------------

  // set_w and clear_w are percentages; three percent go to unused codes and the rest to tests and finds
  function automatic func_t pick_func(input int set_w, input int clear_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      return func_t'($urandom_range(int'(FN_FIND_CLEAR) + 1, FUNC_CODES - 1));
    end
    r = r - 3;
    if (r < set_w) begin
      return FN_SET;
    end
    if (r < set_w + clear_w) begin
      return FN_CLEAR;
    end
    case ($urandom_range(0, 2))
      0:       return FN_TEST;
      1:       return FN_FIND_SET;
      default: return FN_FIND_CLEAR;
    endcase
  endfunction

  // mostly inside a 64-bit window so words fill up and searches cross them
  function automatic pos_t pick_pos(input int win_lo);
    int p;
    if ($urandom_range(0, 99) < 60) begin
      p = $urandom_range(win_lo, win_lo + 63);
      return pos_t'((p > BITMAP_BITS - 1) ? BITMAP_BITS - 1 : p);
    end
    return pos_t'($urandom_range(0, BITMAP_BITS - 1));
  endfunction

  function automatic limit_t pick_limit(input pos_t p);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return limit_t'($urandom_range(int'(p), BITMAP_BITS));
    end else if (r < 65) begin
      return limit_t'(BITMAP_BITS);
    end else if (r < 80) begin
      return limit_t'($urandom_range(BITMAP_BITS + 1, 2 ** LIMIT_W - 1));
    end
    return limit_t'($urandom_range(0, 2 ** LIMIT_W - 1));
  endfunction

  task automatic run_random_phase(input int count, input int set_w,
                                  input int clear_w);
    int    win_lo;
    pos_t  p;
    func_t f;
    win_lo = $urandom_range(0, BITMAP_BITS - 64);
    for (int i = 0; i < count; i++) begin
      // move the window now and then so other words get their turn
      if ($urandom_range(0, 49) == 0) begin
        win_lo = $urandom_range(0, BITMAP_BITS - 64);
      end
      f = pick_func(set_w, clear_w);
      p = pick_pos(win_lo);
      send_item(f, p, pick_limit(p));
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // boundary bits, word edges, limit handling and unused codes
  task automatic test_directed;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    send_item(FN_TEST,       8'd0,   9'd0);
    send_item(FN_FIND_SET,   8'd0,   9'd256);  // empty bitmap, miss
    send_item(FN_FIND_CLEAR, 8'd0,   9'd511);  // oversized limit
    send_item(FN_SET,        8'd0,   9'd0);
    send_item(FN_SET,        8'd31,  9'd511);
    send_item(FN_SET,        8'd32,  9'd256);
    send_item(FN_SET,        8'd255, 9'd0);
    send_item(FN_TEST,       8'd255, 9'd511);
    send_item(FN_TEST,       8'd1,   9'd256);
    send_item(FN_FIND_SET,   8'd1,   9'd256);  // hit at top of word zero
    send_item(FN_FIND_SET,   8'd33,  9'd511);  // saturated limit, hit at 255
    send_item(FN_FIND_SET,   8'd33,  9'd255);  // stops one short of 255
    send_item(FN_FIND_SET,   8'd200, 9'd100);  // start past the limit
    send_item(FN_FIND_CLEAR, 8'd100, 9'd100);  // start at the limit
    send_item(FN_FIND_SET,   8'd0,   9'd0);    // zero limit
    send_item(FN_FIND_CLEAR, 8'd255, 9'd256);  // last bit set, miss
    send_item(FN_FIND_CLEAR, 8'd31,  9'd256);  // skips 31 and 32
    for (int c = int'(FN_FIND_CLEAR) + 1; c < FUNC_CODES; c++) begin
      send_item(func_t'(c), 8'd255, 9'd511);
    end
    send_item(FN_CLEAR,      8'd255, 9'd511);
    send_item(FN_CLEAR,      8'd0,   9'd0);
    send_item(FN_FIND_SET,   8'd0,   9'd256);
    send_item(FN_TEST,       8'd0,   9'd256);
  endtask

  // mostly sets, so windows fill and find-clear has long runs to cross
  task automatic test_fill;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    run_random_phase(200, 55, 5);
  endtask

  // mostly clears, so find-set walks over empty words
  task automatic test_drain;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b0;
    run_random_phase(150, 5, 55);
  endtask

  // back to back transfers with no idling on either side
  task automatic test_burst;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    run_random_phase(100, 25, 25);
  endtask

  // balanced mix with idling on both sides
  task automatic test_mixed;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    run_random_phase(150, 25, 25);
  endtask

  initial begin
    mismatch_count  = 0;
    results_checked = 0;
    find_hits       = 0;
    find_misses     = 0;
    stall_left      = 0;
    in_idle_on      = 1'b0;
    out_idle_on     = 1'b0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (bitmap_image[i]) bitmap_image[i] = '0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    func         <= FN_SET;
    bit_position <= '0;
    search_limit <= '0;
    out_stall    <= 1'b0;
    idle_cycles  <= 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill();
    test_drain();
    test_burst();
    test_mixed();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d results: %0d set, %0d clear, %0d test", results_checked,
             op_count[FN_SET], op_count[FN_CLEAR], op_count[FN_TEST]);
    $display("searches: %0d find-set, %0d find-clear, %0d hit, %0d missed",
             op_count[FN_FIND_SET], op_count[FN_FIND_CLEAR], find_hits, find_misses);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== bitmap_find_next_engine.f =====
rtl/core/bfn_pkg.sv
rtl/core/bfn_ctrl.sv
rtl/core/bfn_dp.sv
rtl/core/bitmap_find_next_engine.sv
rtl/core/bfn_checker.sv
verif/tb_top.sv
